FILE: rtl/csi_pkg.sv
`default_nettype none

package csi_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_PKT_END = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  localparam logic [2:0] REG_FAST_COEF   = 3'd0;
  localparam logic [2:0] REG_BASE_COEF   = 3'd1;
  localparam logic [2:0] REG_DEV_COEF    = 3'd2;
  localparam logic [2:0] REG_LEVEL_DECAY = 3'd3;
  localparam logic [2:0] REG_DEV_DECAY   = 3'd4;
  localparam logic [2:0] REG_GAIN        = 3'd5;

  localparam logic [15:0] FAST_COEF_RST   = 16'd22938;
  localparam logic [15:0] BASE_COEF_RST   = 16'd3277;
  localparam logic [15:0] DEV_COEF_RST    = 16'd16384;
  localparam logic [15:0] LEVEL_DECAY_RST = 16'd60293;
  localparam logic [15:0] DEV_DECAY_RST   = 16'd53740;
  localparam logic [7:0]  GAIN_RST        = 8'd18;

  typedef struct packed {
    logic [15:0] fast_coef;
    logic [15:0] base_coef;
    logic [15:0] dev_coef;
    logic [15:0] level_decay;
    logic [15:0] dev_decay;
    logic [7:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [15:0] count;
    logic [31:0] total;
  } tick_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIV, BK_L1, BK_L2, BK_LW, BK_B1, BK_B2, BK_BW,
    BK_DF, BK_D1, BK_D2, BK_DW, BK_SQ, BK_RI, BK_RT, BK_OUT
  } bk_state_t;

endpackage

`default_nettype wire

FILE: rtl/csi_front.sv
`default_nettype none

module csi_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        mode,
  input  wire logic signed [7:0] i_part,
  input  wire logic signed [7:0] q_part,
  input  wire logic              lead_invalid,
  output logic                   tick_push,
  output csi_pkg::tick_t         tick_data
);

  logic [31:0] window_sum;
  logic [15:0] window_count;
  logic [1:0]  pairs;
  logic [31:0] total;
  logic [7:0]  mag_i;
  logic [7:0]  mag_q;
  logic        skip;

  assign mag_i = i_part[7] ? 8'(-i_part) : 8'(i_part);
  assign mag_q = q_part[7] ? 8'(-q_part) : 8'(q_part);
  assign skip  = lead_invalid && (pairs < 2'd2);

  assign tick_push       = accept && (mode == csi_pkg::MODE_TICK);
  assign tick_data.sum   = window_sum;
  assign tick_data.count = window_count;
  assign tick_data.total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      window_count <= '0;
      pairs        <= '0;
      total        <= '0;
    end else if (accept) begin
      unique case (mode)
        csi_pkg::MODE_SAMPLE: begin
          if (pairs < 2'd2) pairs <= pairs + 2'd1;
          if (!skip) window_sum <= window_sum + 32'(mag_i) + 32'(mag_q);
        end
        csi_pkg::MODE_PKT_END: begin
          if (window_count != 16'hFFFF) window_count <= window_count + 16'd1;
          total <= total + 32'd1;
          pairs <= '0;
        end
        csi_pkg::MODE_TICK: begin
          window_sum   <= '0;
          window_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csi_tick_queue.sv
`default_nettype none

module csi_tick_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  csi_pkg::tick_t      push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output csi_pkg::tick_t      head
);

  csi_pkg::tick_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csi_back.sv
`default_nettype none

module csi_back #(
  parameter int FRAC_BITS = csi_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  csi_pkg::cfg_t    cfg,
  input  wire logic        q_valid,
  input  csi_pkg::tick_t   q_head,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_valid,
  output logic [15:0]      window_packets,
  output logic [15:0]      level,
  output logic [15:0]      baseline,
  output logic [15:0]      deviation,
  output logic [7:0]       activity,
  output logic [31:0]      total_packets
);

  localparam int AVG_W = 16 + FRAC_BITS;
  localparam int ACC_W = AVG_W + 16;
  localparam int DIV_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  csi_pkg::bk_state_t state, state_next;
  csi_pkg::tick_t     tick;

  logic [AVG_W-1:0] lvl, base, dev, diff;
  logic [ACC_W-1:0] acc;
  logic [16:0]      rem;
  logic [DIV_W-1:0] dvd, quo;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      g2;
  logic [31:0]      sv;
  logic [17:0]      srem;
  logic [15:0]      root;

  logic             has_pkt;
  logic [AVG_W-1:0] mean;
  logic [AVG_W-1:0] mul_a;
  logic [16:0]      mul_b;
  logic [AVG_W+16:0] prod;
  logic             acc_add;
  logic [16:0]      rem_sh;
  logic [17:0]      srem_sh, trial;

  assign has_pkt = (tick.count != 16'd0);
  assign mean    = (|quo[DIV_W-1:AVG_W]) ? '1 : quo[AVG_W-1:0];
  assign prod    = (AVG_W+17)'(mul_a) * (AVG_W+17)'(mul_b);
  assign rem_sh  = {rem[15:0], dvd[DIV_W-1]};
  assign srem_sh = {srem[15:0], sv[31:30]};
  assign trial   = {root, 2'b01};

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_a      = lvl;
    mul_b      = 17'h10000 - 17'(cfg.fast_coef);
    acc_add    = 1'b0;
    unique case (state)
      csi_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_head.count != 16'd0) ? csi_pkg::BK_DIV : csi_pkg::BK_L1;
        end
      end
      csi_pkg::BK_DIV: if (cnt == CNT_W'(DIV_W - 1)) state_next = csi_pkg::BK_L1;
      csi_pkg::BK_L1: begin
        if (!has_pkt) mul_b = {1'b0, cfg.level_decay};
        state_next = has_pkt ? csi_pkg::BK_L2 : csi_pkg::BK_LW;
      end
      csi_pkg::BK_L2: begin
        mul_a      = mean;
        mul_b      = {1'b0, cfg.fast_coef};
        acc_add    = 1'b1;
        state_next = csi_pkg::BK_LW;
      end
      csi_pkg::BK_LW: state_next = csi_pkg::BK_B1;
      csi_pkg::BK_B1: begin
        mul_a      = base;
        mul_b      = 17'h10000 - 17'(cfg.base_coef);
        state_next = csi_pkg::BK_B2;
      end
      csi_pkg::BK_B2: begin
        mul_b      = {1'b0, cfg.base_coef};
        acc_add    = 1'b1;
        state_next = csi_pkg::BK_BW;
      end
      csi_pkg::BK_BW: state_next = csi_pkg::BK_DF;
      csi_pkg::BK_DF: state_next = csi_pkg::BK_D1;
      csi_pkg::BK_D1: begin
        mul_a      = dev;
        mul_b      = has_pkt ? 17'h10000 - 17'(cfg.dev_coef) : {1'b0, cfg.dev_decay};
        state_next = has_pkt ? csi_pkg::BK_D2 : csi_pkg::BK_DW;
      end
      csi_pkg::BK_D2: begin
        mul_a      = diff;
        mul_b      = {1'b0, cfg.dev_coef};
        acc_add    = 1'b1;
        state_next = csi_pkg::BK_DW;
      end
      csi_pkg::BK_DW: state_next = csi_pkg::BK_SQ;
      csi_pkg::BK_SQ: begin
        mul_a      = dev;
        mul_b      = {1'b0, g2};
        state_next = csi_pkg::BK_RI;
      end
      csi_pkg::BK_RI: state_next = csi_pkg::BK_RT;
      csi_pkg::BK_RT: if (cnt == CNT_W'(15)) state_next = csi_pkg::BK_OUT;
      csi_pkg::BK_OUT: if (!out_valid) state_next = csi_pkg::BK_IDLE;
      default: state_next = csi_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= csi_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl       <= '0;
      base      <= '0;
      dev       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_pop) out_valid <= 1'b0;
      unique case (state)
        csi_pkg::BK_LW: lvl  <= acc[ACC_W-1:16];
        csi_pkg::BK_BW: base <= acc[ACC_W-1:16];
        csi_pkg::BK_DW: dev  <= acc[ACC_W-1:16];
        csi_pkg::BK_OUT: if (!out_valid) out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc <= (acc_add ? acc : '0) + prod[ACC_W-1:0];
    unique case (state)
      csi_pkg::BK_IDLE: begin
        tick <= q_head;
        dvd  <= DIV_W'(q_head.sum) << FRAC_BITS;
        quo  <= '0;
        rem  <= '0;
        cnt  <= '0;
      end
      csi_pkg::BK_DIV: begin
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
        if (rem_sh >= {1'b0, tick.count}) begin
          rem <= rem_sh - {1'b0, tick.count};
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
      end
      csi_pkg::BK_DF: diff <= (lvl >= base) ? lvl - base : base - lvl;
      csi_pkg::BK_DW: g2 <= 16'(cfg.gain) * 16'(cfg.gain);
      csi_pkg::BK_RI: begin
        sv   <= acc[FRAC_BITS+31:FRAC_BITS];
        srem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      csi_pkg::BK_RT: begin
        sv  <= sv << 2;
        cnt <= cnt + CNT_W'(1);
        if (srem_sh >= trial) begin
          srem <= srem_sh - trial;
          root <= {root[14:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[14:0], 1'b0};
        end
      end
      csi_pkg::BK_OUT: begin
        if (!out_valid) begin
          window_packets <= tick.count;
          level          <= lvl[AVG_W-1:FRAC_BITS];
          baseline       <= base[AVG_W-1:FRAC_BITS];
          deviation      <= dev[AVG_W-1:FRAC_BITS];
          activity       <= (|root[15:8]) ? 8'hFF : root[7:0];
          total_packets  <= tick.total;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/csi_activity_detector_top.sv
`default_nettype none

// Samples and packet ends are taken one per cycle; input stalls only while full is high.
// A window tick holds the back end through a one bit per cycle restoring divide (skipped
// when the window has no packets), shared-multiplier EMA steps and a bit-serial root,
// then until the previous result has been popped.
// Two ticks can wait ahead of the back end; full rises only when both slots are taken.
// Synchronous reset clears all averages, counters and queues and restores the registers.

module csi_activity_detector_top #(
  parameter int FRAC_BITS = csi_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        mode,
  input  wire logic signed [7:0] i_part,
  input  wire logic signed [7:0] q_part,
  input  wire logic              lead_invalid,
  output logic                   empty,
  input  wire logic              pop,
  output logic [15:0]            window_packets,
  output logic [15:0]            level,
  output logic [15:0]            baseline,
  output logic [15:0]            deviation,
  output logic [7:0]             activity,
  output logic [31:0]            total_packets,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  csi_pkg::cfg_t  cfg;
  csi_pkg::tick_t tick_data, q_head;
  logic           tick_push, q_valid, q_pop, out_valid, accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_coef   <= csi_pkg::FAST_COEF_RST;
      cfg.base_coef   <= csi_pkg::BASE_COEF_RST;
      cfg.dev_coef    <= csi_pkg::DEV_COEF_RST;
      cfg.level_decay <= csi_pkg::LEVEL_DECAY_RST;
      cfg.dev_decay   <= csi_pkg::DEV_DECAY_RST;
      cfg.gain        <= csi_pkg::GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csi_pkg::REG_FAST_COEF:   cfg.fast_coef   <= cfg_data;
        csi_pkg::REG_BASE_COEF:   cfg.base_coef   <= cfg_data;
        csi_pkg::REG_DEV_COEF:    cfg.dev_coef    <= cfg_data;
        csi_pkg::REG_LEVEL_DECAY: cfg.level_decay <= cfg_data;
        csi_pkg::REG_DEV_DECAY:   cfg.dev_decay   <= cfg_data;
        csi_pkg::REG_GAIN:        cfg.gain        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  csi_front u_front (
    .clk, .rst, .accept, .mode, .i_part, .q_part, .lead_invalid,
    .tick_push, .tick_data
  );

  csi_tick_queue u_queue (
    .clk, .rst, .push(tick_push), .push_data(tick_data), .pop(q_pop),
    .full, .valid(q_valid), .head(q_head)
  );

  csi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .cfg, .q_valid, .q_head, .q_pop, .out_pop(pop), .out_valid,
    .window_packets, .level, .baseline, .deviation, .activity, .total_packets
  );

`ifndef ASSERT_OFF
  a_cfg_fast: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == csi_pkg::REG_FAST_COEF)
      |=> cfg.fast_coef == $past(cfg_data))
    else $error("fast coefficient write lost");
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop && !tick_push) |=> q_valid && $stable(q_head))
    else $error("waiting tick changed before the back end took it");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(level) && $stable(activity))
    else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire

FILE: test/tb_csi_activity_detector_top.sv
`timescale 1ns / 100ps

module tb_csi_activity_detector_top;

  localparam int FB = csi_pkg::FRAC_BITS_DEF;
  localparam longint unsigned AVG_TOP = (64'd1 << (16 + FB)) - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [15:0] wpk;
    logic [15:0] lvl;
    logic [15:0] bas;
    logic [15:0] dvn;
    logic [7:0]  act;
    logic [31:0] tot;
  } meter_t;

  typedef struct {
    logic [1:0]  m;
    logic [7:0]  ip;
    logic [7:0]  qp;
    logic        lead;
    bit          fixed;
    meter_t      val;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] mode = csi_pkg::MODE_SAMPLE;
  logic signed [7:0] i_part = '0;
  logic signed [7:0] q_part = '0;
  logic lead_invalid = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] window_packets, level, baseline, deviation;
  logic [7:0] activity;
  logic [31:0] total_packets;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  csi_activity_detector_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .i_part(i_part),
    .q_part(q_part), .lead_invalid(lead_invalid), .empty(empty), .pop(pop),
    .window_packets(window_packets), .level(level), .baseline(baseline),
    .deviation(deviation), .activity(activity), .total_packets(total_packets),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the detector state and registers.
  logic [15:0] k_fast, k_base, k_dev, k_ldec, k_ddec;
  logic [7:0]  k_gain;
  logic [31:0] acc_sum;
  logic [15:0] acc_pkts;
  logic [1:0]  lead_seen;
  longint unsigned lvl_ema, base_ema, dev_ema;
  logic [31:0] pkt_count;

  meter_t meter_q[$];
  row_t rows[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int pop_hold = 0;

  function automatic longint unsigned mix(longint unsigned old, longint unsigned x,
                                          logic [15:0] c);
    return (old * (64'd65536 - c) + x * c) >> 16;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] mag(logic [7:0] v);
    return v[7] ? 8'(9'd256 - v) : v;
  endfunction

  task automatic clear_shadow();
    k_fast = csi_pkg::FAST_COEF_RST;
    k_base = csi_pkg::BASE_COEF_RST;
    k_dev = csi_pkg::DEV_COEF_RST;
    k_ldec = csi_pkg::LEVEL_DECAY_RST;
    k_ddec = csi_pkg::DEV_DECAY_RST;
    k_gain = csi_pkg::GAIN_RST;
    acc_sum = '0;
    acc_pkts = '0;
    lead_seen = '0;
    lvl_ema = 0;
    base_ema = 0;
    dev_ema = 0;
    pkt_count = '0;
  endtask

  // Advances the shadow state by one accepted request; returns 1 on a window close.
  function automatic bit predict_meter(logic [1:0] m, logic [7:0] ip, logic [7:0] qp,
                                       logic lead, output meter_t r);
    bit skip;
    longint unsigned avg, diff, sc, rt;
    r = '{default: '0};
    case (m)
      csi_pkg::MODE_SAMPLE: begin
        skip = lead && lead_seen < 2;
        if (lead_seen < 2) lead_seen = lead_seen + 1;
        if (!skip) acc_sum = acc_sum + mag(ip) + mag(qp);
        return 1'b0;
      end
      csi_pkg::MODE_PKT_END: begin
        if (acc_pkts != 16'hFFFF) acc_pkts = acc_pkts + 1;
        pkt_count = pkt_count + 1;
        lead_seen = '0;
        return 1'b0;
      end
      csi_pkg::MODE_TICK: begin
        if (acc_pkts != 0) begin
          avg = (longint'(acc_sum) << FB) / acc_pkts;
          if (avg > AVG_TOP) avg = AVG_TOP;
          lvl_ema = mix(lvl_ema, avg, k_fast);
        end else begin
          lvl_ema = (lvl_ema * k_ldec) >> 16;
        end
        base_ema = mix(base_ema, lvl_ema, k_base);
        diff = (lvl_ema >= base_ema) ? lvl_ema - base_ema : base_ema - lvl_ema;
        if (acc_pkts != 0) dev_ema = mix(dev_ema, diff, k_dev);
        else dev_ema = (dev_ema * k_ddec) >> 16;
        sc = (longint'(k_gain) * k_gain * dev_ema) >> FB;
        rt = int_root(sc);
        if (rt > 255) rt = 255;
        r.wpk = acc_pkts;
        r.lvl = 16'(lvl_ema >> FB);
        r.bas = 16'(base_ema >> FB);
        r.dvn = 16'(dev_ema >> FB);
        r.act = 8'(rt);
        r.tot = pkt_count;
        acc_sum = '0;
        acc_pkts = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    meter_t w;
    if (!rst && pop && !empty) begin
      if (meter_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = meter_q.pop_front();
        if (window_packets !== w.wpk) report_mismatch("window_packets", window_packets, w.wpk);
        if (level !== w.lvl) report_mismatch("level", level, w.lvl);
        if (baseline !== w.bas) report_mismatch("baseline", baseline, w.bas);
        if (deviation !== w.dvn) report_mismatch("deviation", deviation, w.dvn);
        if (activity !== w.act) report_mismatch("activity", activity, w.act);
        if (total_packets !== w.tot) report_mismatch("total_packets", total_packets, w.tot);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop_hold--;
        pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        pop_hold = $urandom_range(1, 13) - 1;
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] m, logic [7:0] ip, logic [7:0] qp, logic lead,
                           bit fixed = 1'b0, meter_t val = '{default: '0});
    meter_t r;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    push = 1'b1;
    mode = m;
    i_part = ip;
    q_part = qp;
    lead_invalid = lead;
    do @(posedge clk); while (full);
    if (predict_meter(m, ip, qp, lead, r)) meter_q.push_back(fixed ? val : r);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (meter_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      csi_pkg::REG_FAST_COEF:   k_fast = d;
      csi_pkg::REG_BASE_COEF:   k_base = d;
      csi_pkg::REG_DEV_COEF:    k_dev = d;
      csi_pkg::REG_LEVEL_DECAY: k_ldec = d;
      csi_pkg::REG_DEV_DECAY:   k_ddec = d;
      csi_pkg::REG_GAIN:        k_gain = d[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(logic [1:0] m, logic [7:0] ip, logic [7:0] qp, logic lead,
                         bit fixed = 1'b0);
    row_t t;
    t.m = m;
    t.ip = ip;
    t.qp = qp;
    t.lead = lead;
    t.fixed = fixed;
    t.val = '{default: '0};
    rows.push_back(t);
  endtask

  task automatic random_run(int n);
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        send_item(csi_pkg::MODE_SAMPLE, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 87) begin
        send_item(csi_pkg::MODE_PKT_END, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 98) begin
        send_item(csi_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_item(2'd3, 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    send_item(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
  endtask

  initial begin
    int k;
    clear_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0, 1'b1);
    add_row(csi_pkg::MODE_SAMPLE, 8'h80, 8'h7F, 1'b0);
    add_row(csi_pkg::MODE_SAMPLE, 8'h7F, 8'h80, 1'b0);
    add_row(csi_pkg::MODE_SAMPLE, 8'hFF, 8'h01, 1'b0);
    add_row(csi_pkg::MODE_PKT_END, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_SAMPLE, 8'h80, 8'h80, 1'b1);
    add_row(csi_pkg::MODE_SAMPLE, 8'h80, 8'h80, 1'b1);
    add_row(csi_pkg::MODE_SAMPLE, 8'h10, 8'h20, 1'b1);
    add_row(csi_pkg::MODE_PKT_END, 8'd0, 8'd0, 1'b1);
    add_row(2'd3, 8'hFF, 8'hFF, 1'b1);
    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_SAMPLE, 8'h55, 8'hAA, 1'b1);
    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_SAMPLE, 8'h33, 8'hCC, 1'b1);
    add_row(csi_pkg::MODE_SAMPLE, 8'h7F, 8'h7F, 1'b1);
    add_row(csi_pkg::MODE_PKT_END, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    add_row(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    foreach (rows[n]) send_item(rows[n].m, rows[n].ip, rows[n].qp, rows[n].lead,
                                rows[n].fixed, rows[n].val);
    drain();

    // A huge window sum over one packet drives the mean into saturation.
    for (k = 0; k < 300; k++) send_item(csi_pkg::MODE_SAMPLE, 8'h80, 8'h80, 1'b0);
    send_item(csi_pkg::MODE_PKT_END, 8'd0, 8'd0, 1'b0);
    send_item(csi_pkg::MODE_TICK, 8'd0, 8'd0, 1'b0);
    random_run(20);
    drain();

    cfg_write(csi_pkg::REG_FAST_COEF, 16'hFFFF);
    cfg_write(csi_pkg::REG_BASE_COEF, 16'hFFFF);
    cfg_write(csi_pkg::REG_DEV_COEF, 16'hFFFF);
    cfg_write(csi_pkg::REG_LEVEL_DECAY, 16'hFFFF);
    cfg_write(csi_pkg::REG_DEV_DECAY, 16'hFFFF);
    cfg_write(csi_pkg::REG_GAIN, 16'h00FF);
    cfg_write(3'd6, 16'h0000);
    random_run(20);
    drain();

    cfg_write(csi_pkg::REG_FAST_COEF, 16'h0000);
    cfg_write(csi_pkg::REG_BASE_COEF, 16'h0000);
    cfg_write(csi_pkg::REG_DEV_COEF, 16'h0000);
    cfg_write(csi_pkg::REG_LEVEL_DECAY, 16'h0000);
    cfg_write(csi_pkg::REG_DEV_DECAY, 16'h0000);
    cfg_write(csi_pkg::REG_GAIN, 16'h0000);
    cfg_write(3'd7, 16'hFFFF);
    random_run(20);
    drain();

    for (k = 0; k < 6; k++) cfg_write(3'(k), 16'($urandom));
    random_run(20);
    drain();

    cfg_write(csi_pkg::REG_FAST_COEF, 16'(22938 + $urandom_range(0, 20000)));
    cfg_write(csi_pkg::REG_BASE_COEF, 16'($urandom_range(1000, 9000)));
    cfg_write(csi_pkg::REG_DEV_COEF, 16'($urandom_range(8000, 30000)));
    cfg_write(csi_pkg::REG_LEVEL_DECAY, 16'($urandom));
    cfg_write(csi_pkg::REG_DEV_DECAY, 16'($urandom));
    cfg_write(csi_pkg::REG_GAIN, 16'($urandom_range(1, 255)));
    quiet = 1'b1;
    random_run(20);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
